// ----- rtl/core/point_in_polygon_test_macros.svh -----
// ----------------------------------------------------------------------------
// Point-in-polygon test: assertion macros
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// Checked only while the block is out of reset.
`define PIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PIP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// Point-in-polygon test: package
// Command and status codes and the controller state type.
// ----------------------------------------------------------------------------
package pip_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_SHORT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/core/pip_if.sv -----
// ----------------------------------------------------------------------------
// Point-in-polygon test: channel interfaces
// Request channel (command and coordinates) and result channel.
// ----------------------------------------------------------------------------
interface pip_req_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   cmd;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;

    modport source (output valid, cmd, x_coord, y_coord, input ready);
    modport sink   (input valid, cmd, x_coord, y_coord, output ready);
endinterface

interface pip_res_if;
    logic       valid;
    logic       ready;
    logic       inside_res;
    logic [1:0] status;

    modport source (output valid, inside_res, status, input ready);
    modport sink   (input valid, inside_res, status, output ready);
endinterface

// ----- rtl/core/point_in_polygon_test.sv -----
// ----------------------------------------------------------------------------
// Point-in-polygon test
// Even-odd ray casting over a polygon held in a vertex memory.
//
//   Channel  Dir  Payload                       Handshake
//   i_req    in   cmd, x_coord, y_coord         valid/ready
//   o_res    out  inside_res, status            valid/ready
//
// Clear, append and short queries pass from the idle state straight to the emit
// state. A query accepts the request, makes n + 1 memory reads through the
// single read port, drains the edge pipeline and then loads the output register.
// A finished result waits in the output register while the next request is
// accepted; a new result waits in its emit cycle while that register is full.
// Reset empties the polygon at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_macros.svh"

module point_in_polygon_test #(
    parameter int MAX_VERTS  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pip_req_if.sink   i_req,
    pip_res_if.source o_res
);
    import pip_pkg::*;

    localparam int CW = $clog2(MAX_VERTS + 1);
    localparam int IW = $clog2(MAX_VERTS);
    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam int MW = 2 * COORD_BITS;

    // Vertex memory, one {y, x} word per vertex.
    logic [MW-1:0] r_mem [MAX_VERTS];
    logic [MW-1:0] r_rd_data;

    t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_step;
    logic          r_rd_v;

    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [MW-1:0] r_prev;
    logic          r_prev_v;

    logic                 r_a_v, r_a_cross, r_a_dpos;
    logic signed [EW-1:0] r_e1, r_d, r_e2, r_e3;
    logic                 r_b_v, r_b_cross, r_b_dpos;
    logic signed [PW-1:0] r_p1, r_p2;
    logic                 r_parity;

    logic    r_res_inside;
    t_status r_res_status;
    logic    r_out_valid;
    logic    r_out_inside;
    t_status r_out_status;

    logic          in_ready, accept, issue, drain_done, emit_load, wr_en;
    logic [CW-1:0] rd_addr_full;
    logic [IW-1:0] rd_addr;

    logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y;
    logic                         a_up, b_up, hit;

    assign accept = i_req.valid && in_ready;
    assign wr_en  = accept && (i_req.cmd == CMD_APPEND) && (r_count < CW'(MAX_VERTS));

    // First read fetches the last vertex so that the closing edge comes first.
    assign rd_addr_full = (r_step == '0) ? r_count - CW'(1) : r_step - CW'(1);
    assign rd_addr      = rd_addr_full[IW-1:0];

    assign a_x = r_rd_data[COORD_BITS-1:0];
    assign a_y = r_rd_data[MW-1:COORD_BITS];
    assign b_x = r_prev[COORD_BITS-1:0];
    assign b_y = r_prev[MW-1:COORD_BITS];
    assign a_up = a_y > r_py;
    assign b_up = b_y > r_py;

    // With a positive y span the test is e1*d < e2*e3; a negative span flips it.
    assign hit = r_b_dpos ? (r_p1 < r_p2) : (r_p1 > r_p2);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_req.cmd == CMD_QUERY) && (r_count >= CW'(3))) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                if (r_step == r_count) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (drain_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        in_ready   = 1'b0;
        issue      = 1'b0;
        drain_done = 1'b0;
        emit_load  = 1'b0;
        case (r_state)
            S_IDLE:  in_ready = 1'b1;
            S_SCAN:  issue = 1'b1;
            S_DRAIN: drain_done = !r_rd_v && !r_a_v && !r_b_v;
            S_EMIT:  emit_load = !r_out_valid || o_res.ready;
            default: in_ready = 1'b0;
        endcase
    end

    assign i_req.ready      = in_ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.inside_res = r_out_inside;
    assign o_res.status     = r_out_status;

    // Memory port: one write, one registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IW-1:0]] <= {i_req.y_coord, i_req.x_coord};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_rd_v      <= 1'b0;
            r_prev_v    <= 1'b0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= issue;
            r_a_v   <= r_rd_v && r_prev_v;
            r_b_v   <= r_a_v;
            if (issue) begin
                r_step <= r_step + CW'(1);
            end
            if (r_rd_v) begin
                r_prev_v <= 1'b1;
            end
            if (r_b_v && r_b_cross && hit) begin
                r_parity <= !r_parity;
            end
            if (accept) begin
                r_step   <= '0;
                r_prev_v <= 1'b0;
                r_parity <= 1'b0;
                if (i_req.cmd == CMD_CLEAR) begin
                    r_count <= '0;
                end else if (wr_en) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Edge pipeline and result payload.
    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_prev <= r_rd_data;
        end
        r_a_cross <= a_up != b_up;
        r_d       <= EW'(b_y) - EW'(a_y);
        r_a_dpos  <= b_y > a_y;
        r_e1      <= EW'(r_px) - EW'(a_x);
        r_e2      <= EW'(b_x) - EW'(a_x);
        r_e3      <= EW'(r_py) - EW'(a_y);
        r_b_cross <= r_a_cross;
        r_b_dpos  <= r_a_dpos;
        r_p1      <= PW'(r_e1) * PW'(r_d);
        r_p2      <= PW'(r_e2) * PW'(r_e3);
        if (accept) begin
            r_px         <= i_req.x_coord;
            r_py         <= i_req.y_coord;
            r_res_inside <= 1'b0;
            case (t_cmd'(i_req.cmd))
                CMD_APPEND: begin
                    r_res_status <= wr_en ? STAT_OK : STAT_FULL;
                end
                CMD_QUERY: begin
                    r_res_status <= (r_count < CW'(3)) ? STAT_SHORT : STAT_OK;
                end
                default: r_res_status <= STAT_OK;
            endcase
        end
        if (drain_done) begin
            r_res_inside <= r_parity;
        end
        if (emit_load) begin
            r_out_inside <= r_res_inside;
            r_out_status <= r_res_status;
        end
    end

    `PIP_ASSERT(a_accept_leaves_idle, accept |=> (r_state != S_IDLE),
        "request accepted but controller stayed idle")
    `PIP_ASSERT(a_pipe_in_query,
        (r_rd_v || r_a_v || r_b_v) |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)),
        "edge pipeline active outside a query")
    `PIP_ASSERT(a_full_keeps_count,
        (accept && (i_req.cmd == CMD_APPEND) && (r_count == CW'(MAX_VERTS)))
            |=> (r_count == $past(r_count)),
        "append to a full store changed the count")
    `PIP_ASSERT_ALWAYS(a_count_bound, (!i_rst_n || (r_count <= CW'(MAX_VERTS))),
        "vertex count beyond capacity")

endmodule

// ----- tb/point_in_polygon_test_test.sv -----
// ----------------------------------------------------------------------------
// Point-in-polygon test: block-level testbench
// Builds polygons through append requests, clears them and queries points
// against them. Each accepted request is run through an even-odd crossing
// predictor kept beside the block. Every result is checked in order against
// the prediction. Both channels idle at random, with bursts that do not idle.
// ----------------------------------------------------------------------------
module point_in_polygon_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    localparam int MAX_VERTS    = 64;
    localparam int COORD_BITS   = 16;
    localparam int ITEM_TARGET  = 1250;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [1:0]        CMD_UNUSED = 2'd3;
    localparam logic signed [15:0] C_MIN     = 16'sh8000;
    localparam logic signed [15:0] C_MAX     = 16'sh7FFF;

    typedef struct packed {
        logic       in_poly;
        logic [1:0] status;
    } t_verdict;

    class polygon_scoreboard;
        logic signed [15:0] vert_x [MAX_VERTS];
        logic signed [15:0] vert_y [MAX_VERTS];
        int unsigned        vert_count;
        t_verdict           pending_verdicts [$];
        int unsigned        n_errors, n_checked, n_queries, n_hits, n_full, n_short;

        function new();
            vert_count = 0;
            n_errors   = 0;
            n_checked  = 0;
            n_queries  = 0;
            n_hits     = 0;
            n_full     = 0;
            n_short    = 0;
        endfunction

        // The crossing x is compared without division: both sides are scaled
        // by the edge's y span, and the right side takes the sign of that span.
        function bit crossing_parity(longint px, longint py);
            bit          odd;
            int unsigned j;
            longint      ax, ay, bx, by, dy, lhs, rhs;
            odd = 1'b0;
            for (int unsigned i = 0; i < vert_count; i++) begin
                j  = (i == 0) ? vert_count - 1 : i - 1;
                ax = vert_x[i];
                ay = vert_y[i];
                bx = vert_x[j];
                by = vert_y[j];
                if ((ay > py) != (by > py)) begin
                    dy  = by - ay;
                    lhs = (px - ax) * ((dy < 0) ? -dy : dy);
                    rhs = (bx - ax) * (py - ay);
                    if (dy < 0)
                        rhs = -rhs;
                    if (lhs < rhs)
                        odd = !odd;
                end
            end
            return odd;
        endfunction

        function void note_request(logic [1:0] cmd, logic signed [15:0] x,
                                   logic signed [15:0] y);
            t_verdict v;
            v.in_poly = 1'b0;
            v.status  = STAT_OK;
            case (cmd)
                CMD_CLEAR: begin
                    vert_count = 0;
                end
                CMD_APPEND: begin
                    if (vert_count < MAX_VERTS) begin
                        vert_x[vert_count] = x;
                        vert_y[vert_count] = y;
                        vert_count++;
                    end else begin
                        v.status = STAT_FULL;
                        n_full++;
                    end
                end
                CMD_QUERY: begin
                    n_queries++;
                    if (vert_count < 3) begin
                        v.status = STAT_SHORT;
                        n_short++;
                    end else begin
                        v.in_poly = crossing_parity(x, y);
                        if (v.in_poly)
                            n_hits++;
                    end
                end
                default: ;
            endcase
            pending_verdicts = {pending_verdicts, v};
        endfunction

        function void check_result(logic in_poly, logic [1:0] status);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with no request outstanding: inside_res %0d status %0d",
                         $time, in_poly, status);
                n_errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            n_checked++;
            if (in_poly !== want.in_poly) begin
                $display("%0t: inside_res mismatch: expected %0d, actual %0d",
                         $time, want.in_poly, in_poly);
                n_errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pip_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
    pip_res_if                            res_ch ();

    point_in_polygon_test #(
        .MAX_VERTS (MAX_VERTS),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_res  (res_ch)
    );

    polygon_scoreboard sb;
    int unsigned       n_sent;
    bit                req_eager;
    bit                res_eager;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int idle_gap(bit eager);
        return eager ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767)
            return C_MAX;
        if (v < -32768)
            return C_MIN;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] near(int centre, int radius);
        return clamp16(centre + int'($urandom_range(0, 2 * radius)) - radius);
    endfunction

    // Called at a rising edge; returns at the edge that accepts the request.
    task automatic send_request(logic [1:0] cmd, logic signed [15:0] x,
                                logic signed [15:0] y);
        int gap;
        gap = idle_gap(req_eager);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= cmd;
        req_ch.x_coord <= x;
        req_ch.y_coord <= y;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_request(cmd, x, y);
        n_sent++;
    endtask

    task automatic polygon_session();
        int                 n, nq, centre_x, centre_y, radius, k, k2, pick;
        logic signed [15:0] sx [MAX_VERTS + 8];
        logic signed [15:0] sy [MAX_VERTS + 8];
        logic signed [15:0] qx, qy;
        case ($urandom_range(0, 3))
            0:       radius = 8;
            1:       radius = 200;
            2:       radius = 5000;
            default: radius = 32767;
        endcase
        centre_x = (radius == 32767) ? 0 : int'($urandom_range(0, 65535)) - 32768;
        centre_y = (radius == 32767) ? 0 : int'($urandom_range(0, 65535)) - 32768;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            n = $urandom_range(1, 2);
        else if (pick < 92)
            n = $urandom_range(3, 12);
        else
            n = $urandom_range(13, MAX_VERTS);
        // Now and then the new vertices extend whatever polygon is held.
        if ($urandom_range(0, 9) != 0)
            send_request(CMD_CLEAR, near(0, 32767), near(0, 32767));
        for (int i = 0; i < n; i++) begin
            sx[i] = near(centre_x, radius);
            sy[i] = near(centre_y, radius);
            send_request(CMD_APPEND, sx[i], sy[i]);
        end
        nq = $urandom_range(2, 8);
        for (int q = 0; q < nq; q++) begin
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, n - 1);
            k2   = (k + 1) % n;
            if (pick < 50) begin
                qx = near(centre_x, radius);
                qy = near(centre_y, radius);
            end else if (pick < 65) begin
                qx = sx[k];
                qy = sy[k];
            end else if (pick < 80) begin
                // Midpoint of an edge: lies on the edge when the spans are even.
                qx = clamp16((int'(sx[k]) + int'(sx[k2])) / 2);
                qy = clamp16((int'(sy[k]) + int'(sy[k2])) / 2);
            end else if (pick < 90) begin
                qx = near(centre_x, radius);
                qy = sy[k];
            end else begin
                qx = 16'($urandom());
                qy = 16'($urandom());
            end
            send_request(CMD_QUERY, qx, qy);
        end
    endtask

    task automatic overflow_session();
        int n;
        n = $urandom_range(MAX_VERTS, MAX_VERTS + 6);
        send_request(CMD_CLEAR, 16'sd0, 16'sd0);
        for (int i = 0; i < n; i++)
            send_request(CMD_APPEND, 16'($urandom()), 16'($urandom()));
        repeat (2) send_request(CMD_QUERY, 16'($urandom()), 16'($urandom()));
    endtask

    task automatic noise_session();
        repeat (6) send_request(2'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()));
    endtask

    // Result side: takes results at its own pace and checks each one.
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = idle_gap(res_eager);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            sb.check_result(res_ch.inside_res, res_ch.status);
        end
    end

    initial begin
        int seq_idx, pick;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = CMD_CLEAR;
        req_ch.x_coord = '0;
        req_ch.y_coord = '0;
        req_eager      = 1'b0;
        res_eager      = 1'b0;
        n_sent         = 0;
        sb             = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty and short polygons, a full-range square with points on its
        // corners, a small triangle with points on its edges, and the unused command.
        send_request(CMD_QUERY,  16'sd0, 16'sd0);
        send_request(CMD_CLEAR,  C_MAX,  C_MIN);
        send_request(CMD_APPEND, C_MIN,  C_MIN);
        send_request(CMD_APPEND, C_MAX,  C_MIN);
        send_request(CMD_QUERY,  16'sd0, 16'sd0);
        send_request(CMD_APPEND, C_MAX,  C_MAX);
        send_request(CMD_APPEND, C_MIN,  C_MAX);
        send_request(CMD_QUERY,  16'sd0, 16'sd0);
        send_request(CMD_QUERY,  C_MIN,  C_MIN);
        send_request(CMD_QUERY,  C_MAX,  C_MAX);
        send_request(CMD_QUERY,  C_MIN,  16'sd0);
        send_request(CMD_QUERY,  C_MAX,  16'sd0);
        send_request(CMD_QUERY,  16'sd0, C_MAX);
        send_request(CMD_UNUSED, -16'sd1, -16'sd1);
        send_request(CMD_QUERY,  -16'sd1, -16'sd1);
        send_request(CMD_CLEAR,  16'sd0, 16'sd0);
        send_request(CMD_APPEND, 16'sd0, 16'sd0);
        send_request(CMD_APPEND, 16'sd100, 16'sd0);
        send_request(CMD_APPEND, 16'sd0, 16'sd100);
        send_request(CMD_QUERY,  16'sd10, 16'sd10);
        send_request(CMD_QUERY,  16'sd60, 16'sd60);
        send_request(CMD_QUERY,  16'sd50, 16'sd50);
        send_request(CMD_QUERY,  16'sd0, 16'sd50);
        send_request(CMD_QUERY,  -16'sd5, 16'sd50);
        send_request(CMD_UNUSED, 16'sd0, 16'sd0);

        seq_idx = 0;
        while (n_sent < ITEM_TARGET) begin
            req_eager = ($urandom_range(0, 4) == 0);
            res_eager = ($urandom_range(0, 4) == 0);
            pick      = $urandom_range(0, 99);
            if (seq_idx % 15 == 1 || pick < 4)
                overflow_session();
            else if (pick < 16)
                noise_session();
            else
                polygon_session();
            seq_idx++;
        end
        req_ch.valid <= 1'b0;

        while (sb.pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests in %0d random sessions; %0d results checked.",
                 n_sent, seq_idx, sb.n_checked);
        $display("Queries: %0d, inside: %0d, short polygon: %0d; appends dropped: %0d.",
                 sb.n_queries, sb.n_hits, sb.n_short, sb.n_full);
        if (sb.n_errors == 0) begin
            $display("point_in_polygon_test test passed");
        end else begin
            $display("point_in_polygon_test test failed");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Timed out with %0d results outstanding.", sb.pending_verdicts.size());
        $display("point_in_polygon_test test failed");
        $finish;
    end

endmodule

// ----- point_in_polygon_test.f -----
+incdir+rtl/core
rtl/core/pip_pkg.sv
rtl/core/pip_if.sv
rtl/core/point_in_polygon_test.sv
tb/point_in_polygon_test_test.sv
